### hdl/krs_pkg.sv
// Package: command and status codes, field widths and control structs of the record store.
`default_nettype none
package krs_pkg;

   // Widths of the beat fields
   localparam int CMD_W    = 2;
   localparam int KEY_W    = 32;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic clear_wr;   // write an empty slot at the sweep address, advance
      logic load;       // capture the request beat, reset the search
      logic scan_rd;    // read the slot at the sweep address, advance
      logic commit;     // apply the update and load the result register
   } krs_ctl_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic addr_last;  // sweep address is at the last slot
      logic rd_pending; // a slot read is still being compared
   } krs_sts_type;

endpackage
`default_nettype wire

### hdl/krs_channels.sv
// Interfaces: request and response channels of the record store.
`default_nettype none
interface krs_req_if;
   logic                        valid;
   logic                        ready;
   logic [krs_pkg::CMD_W-1:0]   cmd;
   logic [krs_pkg::KEY_W-1:0]   key_id;
   logic [krs_pkg::DATA_W-1:0]  payload_in;

   modport source (output valid, output cmd, output key_id, output payload_in,
                   input ready);
   modport sink   (input valid, input cmd, input key_id, input payload_in,
                   output ready);
endinterface

interface krs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [krs_pkg::STATUS_W-1:0]  status;
   logic [krs_pkg::DATA_W-1:0]    payload_out;
   logic [krs_pkg::COUNT_W-1:0]   used_count;
   logic [krs_pkg::COUNT_W-1:0]   free_count;

   modport source (output valid, output status, output payload_out,
                   output used_count, output free_count, input ready);
   modport sink   (input valid, input status, input payload_out,
                   input used_count, input free_count, output ready);
endinterface
`default_nettype wire

### hdl/krs_ctrl.sv
// Controller: state machine sequencing clear, accept, scan, update and response.
`default_nettype none
module krs_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output krs_pkg::krs_ctl_type      ctl,
   input  wire krs_pkg::krs_sts_type sts
);
   import krs_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_SCAN  = 5'b00100,
      S_FLUSH = 5'b01000,
      S_WRITE = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            ctl.clear_wr = 1'b1;
            if (sts.addr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            ctl.scan_rd = 1'b1;
            if (sts.addr_last) begin
               state_in = S_FLUSH;
            end
         end
         S_FLUSH: begin
            state_in = S_WRITE;
         end
         S_WRITE: begin
            // hold until the result register is free
            if (!sts.rd_pending && (!rsp_valid_ff || rsp_ready)) begin
               ctl.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      if (ctl.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_SCAN)
      else $error("accepted beat did not start a scan");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      ctl.commit |=> rsp_valid_ff)
      else $error("commit did not present a result");

   a_write_waits: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WRITE && rsp_valid_ff && !rsp_ready |=> state_ff == S_WRITE)
      else $error("update left while the result register was full");

endmodule
`default_nettype wire

### hdl/krs_dpath.sv
// Datapath: slot memory, sweep counter, match and free search, occupancy and result register.
`default_nettype none
module krs_dpath #(
   parameter int ENTRIES      = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire krs_pkg::krs_ctl_type            ctl,
   output krs_pkg::krs_sts_type                 sts,
   input  wire logic [krs_pkg::CMD_W-1:0]       req_cmd,
   input  wire logic [krs_pkg::KEY_W-1:0]       req_key_id,
   input  wire logic [krs_pkg::DATA_W-1:0]      req_payload_in,
   output logic      [krs_pkg::STATUS_W-1:0]    rsp_status,
   output logic      [krs_pkg::DATA_W-1:0]      rsp_payload_out,
   output logic      [krs_pkg::COUNT_W-1:0]     rsp_used_count,
   output logic      [krs_pkg::COUNT_W-1:0]     rsp_free_count
);
   import krs_pkg::*;

   localparam int AW = $clog2(ENTRIES);
   localparam int OW = $clog2(ENTRIES + 1);
   localparam int PW = PAYLOAD_BITS;
   localparam int WW = 1 + KEY_W + PW;   // valid, key, payload

   // Slot memory: one write port, one registered read port
   logic [WW-1:0]       mem_ff [ENTRIES];
   logic [WW-1:0]       rdata_ff;

   logic [AW-1:0]       addr_ff, addr_in;
   logic                rd_vld_ff;
   logic [AW-1:0]       rd_idx_ff;

   logic [CMD_W-1:0]    cmd_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [PW-1:0]       pay_ff;

   logic                hit_ff, hit_in;
   logic [AW-1:0]       hit_idx_ff, hit_idx_in;
   logic [PW-1:0]       hit_pay_ff, hit_pay_in;
   logic                free_ff, free_in;
   logic [AW-1:0]       free_idx_ff, free_idx_in;

   logic [OW-1:0]       occ_ff, occ_in;

   logic [STATUS_W-1:0] status_ff, status_in;
   logic [DATA_W-1:0]   pout_ff, pout_in;
   logic [COUNT_W-1:0]  used_ff, used_in;
   logic [COUNT_W-1:0]  freec_ff, freec_in;

   logic                rd_valid_bit;
   logic [KEY_W-1:0]    rd_key;
   logic [PW-1:0]       rd_pay;

   logic                upd_wr;
   logic [AW-1:0]       upd_addr;
   logic [WW-1:0]       upd_data;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [WW-1:0]       wr_data;
   logic [31:0]         occ_ext;
   logic [31:0]         free_ext;

   assign sts.addr_last  = (addr_ff == AW'(ENTRIES - 1));
   assign sts.rd_pending = rd_vld_ff;

   // Sweep counter, shared by the clearing pass and the scan
   always_comb begin
      addr_in = addr_ff;
      if (ctl.clear_wr || ctl.scan_rd) begin
         addr_in = sts.addr_last ? '0 : addr_ff + AW'(1);
      end
   end

   assign rd_valid_bit = rdata_ff[WW-1];
   assign rd_key       = rdata_ff[WW-2 -: KEY_W];
   assign rd_pay       = rdata_ff[PW-1:0];

   // Search: first valid slot with the key, first empty slot
   always_comb begin
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_pay_in  = hit_pay_ff;
      free_in     = free_ff;
      free_idx_in = free_idx_ff;
      if (ctl.load) begin
         hit_in  = 1'b0;
         free_in = 1'b0;
      end else if (rd_vld_ff) begin
         if (rd_valid_bit && rd_key == key_ff && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = rd_idx_ff;
            hit_pay_in = rd_pay;
         end
         if (!rd_valid_bit && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = rd_idx_ff;
         end
      end
   end

   // Update and result
   always_comb begin
      upd_wr    = 1'b0;
      upd_addr  = hit_idx_ff;
      upd_data  = '0;
      occ_in    = occ_ff;
      status_in = ST_NOTFOUND;
      pout_in   = '0;
      case (cmd_ff)
         CMD_ADD: begin
            if (hit_ff) begin
               upd_wr    = 1'b1;
               upd_data  = {1'b1, key_ff, pay_ff};
               status_in = ST_REPLACED;
            end else if (free_ff) begin
               upd_wr    = 1'b1;
               upd_addr  = free_idx_ff;
               upd_data  = {1'b1, key_ff, pay_ff};
               occ_in    = occ_ff + OW'(1);
               status_in = ST_INSERTED;
            end else begin
               status_in = ST_FULL;
            end
         end
         CMD_GET: begin
            if (hit_ff) begin
               pout_in   = DATA_W'(hit_pay_ff);
               status_in = ST_FOUND;
            end
         end
         CMD_REMOVE: begin
            if (hit_ff) begin
               upd_wr = 1'b1;
               if (occ_ff != '0) begin
                  occ_in = occ_ff - OW'(1);
               end
               status_in = ST_FOUND;
            end
         end
         default: begin
            status_in = ST_NOTFOUND;
         end
      endcase
      if (!ctl.commit) begin
         occ_in = occ_ff;
      end
   end

   assign occ_ext  = 32'(occ_in);
   assign free_ext = 32'(ENTRIES) - occ_ext;
   assign used_in  = occ_ext[COUNT_W-1:0];
   assign freec_in = free_ext[COUNT_W-1:0];

   assign wr_en   = ctl.clear_wr || (ctl.commit && upd_wr);
   assign wr_addr = ctl.clear_wr ? addr_ff : upd_addr;
   assign wr_data = ctl.clear_wr ? '0 : upd_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.scan_rd) begin
         rdata_ff <= mem_ff[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff   <= '0;
         rd_vld_ff <= 1'b0;
         hit_ff    <= 1'b0;
         free_ff   <= 1'b0;
         occ_ff    <= '0;
      end else begin
         addr_ff   <= addr_in;
         rd_vld_ff <= ctl.scan_rd;
         hit_ff    <= hit_in;
         free_ff   <= free_in;
         occ_ff    <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= addr_ff;
      hit_idx_ff  <= hit_idx_in;
      hit_pay_ff  <= hit_pay_in;
      free_idx_ff <= free_idx_in;
      if (ctl.load) begin
         cmd_ff <= req_cmd;
         key_ff <= req_key_id;
         pay_ff <= PW'(req_payload_in);
      end
      if (ctl.commit) begin
         status_ff <= status_in;
         pout_ff   <= pout_in;
         used_ff   <= used_in;
         freec_ff  <= freec_in;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_payload_out = pout_ff;
   assign rsp_used_count  = used_ff;
   assign rsp_free_count  = freec_ff;

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OW'(ENTRIES))
      else $error("occupancy above capacity");

   a_hit_free_apart: assert property (@(posedge clock) disable iff (reset)
      hit_ff && free_ff |-> hit_idx_ff != free_idx_ff)
      else $error("match and free slot at the same index");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      ctl.commit && cmd_ff == CMD_ADD && !hit_ff && free_ff
      |=> occ_ff == $past(occ_ff) + OW'(1))
      else $error("insert did not advance occupancy");

endmodule
`default_nettype wire

### hdl/keyed_record_store.sv
// Top level: keyed record store, a fixed-capacity key to payload table.
//
//   channel   direction  handshake      beat fields
//   req_bus   in         valid / ready  cmd, key_id, payload_in
//   rsp_bus   out        valid / ready  status, payload_out, used_count, free_count
//
// An item passes through these steps: accept the beat, read every slot in turn through the
// single read port of the slot memory, compare the last slot read, then write the slot and
// load the result register. No new beat is taken until the item has written its slot.
// After reset a clearing pass writes every slot empty, with req ready low.
// The result register frees the input side: a new beat is taken while a result waits,
// and its update holds until that result has been taken.
`default_nettype none
module keyed_record_store #(
   parameter int ENTRIES      = 16,
   parameter int PAYLOAD_BITS = 32
) (
   input  wire logic clock,
   input  wire logic reset,
   krs_req_if.sink   req_bus,
   krs_rsp_if.source rsp_bus
);
   import krs_pkg::*;

   krs_ctl_type ctl;
   krs_sts_type sts;

   // Sequencing: clear sweep, accept, scan, update, result handshake
   krs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .ctl       (ctl),
      .sts       (sts)
   );

   // Storage, search and result fields
   krs_dpath #(
      .ENTRIES      (ENTRIES),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .req_cmd         (req_bus.cmd),
      .req_key_id      (req_bus.key_id),
      .req_payload_in  (req_bus.payload_in),
      .rsp_status      (rsp_bus.status),
      .rsp_payload_out (rsp_bus.payload_out),
      .rsp_used_count  (rsp_bus.used_count),
      .rsp_free_count  (rsp_bus.free_count)
   );

endmodule
`default_nettype wire
